// ===== hdl/voice_reply_frame_checker_core_defines.svh =====
// Assertion macros used by the frame checker assertion module vrfc_checker
`ifndef VOICE_REPLY_FRAME_CHECKER_CORE_DEFINES_SVH
`define VOICE_REPLY_FRAME_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define VRFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VRFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vrfc_pkg.sv =====
// Types and constants of the voice reply frame checker
`default_nettype none

package vrfc_pkg;

    // Verdict codes on the result channel
    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_CS_BAD   = 2'd1,
        VERDICT_LEN_BAD  = 2'd2,
        VERDICT_NO_FRAME = 2'd3
    } verdict_t;

    // Parser phases, one-hot
    typedef enum logic [6:0] {
        PH_HUNT   = 7'b0000001,
        PH_ADDR   = 7'b0000010,
        PH_LEN_HI = 7'b0000100,
        PH_LEN_LO = 7'b0001000,
        PH_BODY   = 7'b0010000,
        PH_CHECK  = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    // Configuration register indexes
    localparam logic [7:0] CFG_START_BYTE   = 8'd0;
    localparam logic [7:0] CFG_ADDRESS_BYTE = 8'd1;

    // Configuration reset values
    localparam logic [7:0] START_BYTE_RESET   = 8'hFE;
    localparam logic [7:0] ADDRESS_BYTE_RESET = 8'h99;

    // Smallest legal length field: length bytes, source, type, checksum
    localparam logic [15:0] MIN_FRAME_LENGTH = 16'd5;

endpackage

`default_nettype wire

// ===== hdl/voice_reply_frame_checker_core.sv =====
// Voice reply frame checker: parses a byte stream and reports one verdict per burst
// Verdicts are registered in the result register, or in the skid while it is held.
// Throughput: one byte per cycle while s_ready is high; state moves per accepted byte.
// A two-entry output buffer (result register plus skid) keeps s_ready high while one
// verdict waits on m_ready; s_ready drops only when both entries are full.
// Reset (aresetn low, synchronous) returns the parser to hunting, empties the output
// buffer and loads the start and address registers with 0xFE and 0x99.
`default_nettype none

module voice_reply_frame_checker_core #(
    parameter int MAX_FRAME_BYTES = 128
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    // byte input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_rx_byte,
    input  wire logic              s_burst_end,
    // verdict output channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output vrfc_pkg::verdict_t     m_verdict,
    output logic [15:0]            m_frame_length
);

    import vrfc_pkg::*;

    localparam int          LeftW    = $clog2(MAX_FRAME_BYTES);
    localparam logic [16:0] MaxFrame = 17'(MAX_FRAME_BYTES);

    // configuration registers
    logic [7:0] start_byte_reg;
    logic [7:0] address_byte_reg;

    // parser state
    phase_t           phase_reg,  phase_next;
    logic [7:0]       xor_reg,    xor_next;
    logic [15:0]      len_reg,    len_next;
    logic [LeftW-1:0] left_reg,   left_next;

    // output buffer
    logic             out_valid_reg;
    verdict_t         out_verdict_reg;
    logic [15:0]      out_len_reg;
    logic             skid_valid_reg;
    verdict_t         skid_verdict_reg;
    logic [15:0]      skid_len_reg;

    // per-byte result
    logic             res_valid;
    verdict_t         res_verdict;
    logic [15:0]      res_len;

    logic             in_fire;
    logic             out_fire;
    logic [15:0]      len_full;
    logic [15:0]      len_minus3;
    logic [16:0]      frame_bytes;
    logic             len_bad;
    logic [LeftW-1:0] left_dec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign in_fire   = s_valid && s_ready;
    assign out_fire  = out_valid_reg && m_ready;

    assign m_valid        = out_valid_reg;
    assign m_verdict      = out_verdict_reg;
    assign m_frame_length = out_len_reg;

    // Length checks on the completed length field
    assign len_full    = {len_reg[15:8], s_rx_byte};
    assign len_minus3  = len_full - 16'd3;
    assign frame_bytes = {1'b0, len_full} + 17'd2;
    assign len_bad     = (len_full < MIN_FRAME_LENGTH) || (frame_bytes > MaxFrame);
    assign left_dec    = left_reg - LeftW'(1);

    // Write configuration registers; ignore unused indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg   <= START_BYTE_RESET;
            address_byte_reg <= ADDRESS_BYTE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_START_BYTE) begin
                start_byte_reg <= cfg_data;
            end else if (cfg_index == CFG_ADDRESS_BYTE) begin
                address_byte_reg <= cfg_data;
            end
        end
    end

    // Advance the parser by one byte
    always_comb begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        res_valid   = 1'b0;
        res_verdict = VERDICT_NO_FRAME;
        res_len     = '0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (s_rx_byte == start_byte_reg) begin
                    phase_next = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (s_rx_byte == address_byte_reg) begin
                    xor_next   = s_rx_byte;
                    phase_next = PH_LEN_HI;
                end else if (s_rx_byte != start_byte_reg) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN_HI: begin
                xor_next   = xor_reg ^ s_rx_byte;
                len_next   = {s_rx_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                xor_next = xor_reg ^ s_rx_byte;
                len_next = len_full;
                if (len_bad) begin
                    res_valid   = 1'b1;
                    res_verdict = VERDICT_LEN_BAD;
                    res_len     = len_full;
                    phase_next  = PH_DONE;
                end else begin
                    left_next  = len_minus3[LeftW-1:0];
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                xor_next  = xor_reg ^ s_rx_byte;
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                res_valid   = 1'b1;
                res_verdict = (s_rx_byte == xor_reg) ? VERDICT_OK : VERDICT_CS_BAD;
                res_len     = len_reg;
                phase_next  = PH_DONE;
            end
            PH_DONE: begin
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase

        // Close the burst: report a missing frame, then clear the parser
        if (s_burst_end) begin
            if (!res_valid && (phase_reg != PH_DONE)) begin
                res_valid   = 1'b1;
                res_verdict = VERDICT_NO_FRAME;
                res_len     = '0;
            end
            phase_next = PH_HUNT;
            xor_next   = '0;
            len_next   = '0;
            left_next  = '0;
        end
    end

    // Hold parser state; update on each input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            xor_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

    // Output buffer valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_fire) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_fire && res_valid;
                end
            end else if (in_fire && res_valid) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Output buffer payload: refill from skid, else load the new verdict
    always_ff @(posedge aclk) begin
        if (out_fire && skid_valid_reg) begin
            out_verdict_reg <= skid_verdict_reg;
            out_len_reg     <= skid_len_reg;
        end else if (in_fire && res_valid && (out_fire || !out_valid_reg)) begin
            out_verdict_reg <= res_verdict;
            out_len_reg     <= res_len;
        end
        if (in_fire && res_valid && out_valid_reg && !out_fire) begin
            skid_verdict_reg <= res_verdict;
            skid_len_reg     <= res_len;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/vrfc_checker.sv =====
// Port-level assertions for the voice reply frame checker, with its bind
`default_nettype none

`include "voice_reply_frame_checker_core_defines.svh"

module vrfc_checker #(
    parameter int MAX_FRAME_BYTES = 128
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire vrfc_pkg::verdict_t m_verdict,
    input wire logic [15:0]        m_frame_length
);

    import vrfc_pkg::*;

    localparam logic [16:0] MaxFrame = 17'(MAX_FRAME_BYTES);

    logic [16:0] frame_bytes;
    logic        len_legal;

    assign frame_bytes = {1'b0, m_frame_length} + 17'd2;
    assign len_legal   = (m_frame_length >= MIN_FRAME_LENGTH) && (frame_bytes <= MaxFrame);

    // A stalled verdict holds
    `VRFC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_verdict) && $stable(m_frame_length), "verdict changed while stalled")

    // No frame reports a zero length
    `VRFC_ASSERT_IMPLY(a_no_frame_len, aclk, aresetn, m_valid && (m_verdict == VERDICT_NO_FRAME), m_frame_length == 16'd0, "no-frame verdict with nonzero length")

    // Checked frames carry a legal length
    `VRFC_ASSERT_IMPLY(a_checked_len, aclk, aresetn, m_valid && ((m_verdict == VERDICT_OK) || (m_verdict == VERDICT_CS_BAD)), len_legal, "checked frame with illegal length")

    // Bad length verdicts carry an illegal length
    `VRFC_ASSERT_IMPLY(a_bad_len, aclk, aresetn, m_valid && (m_verdict == VERDICT_LEN_BAD), !len_legal, "bad-length verdict with legal length")

    // Input stalls only behind a waiting verdict
    `VRFC_ASSERT_IMPLY(a_stall_out, aclk, aresetn, !s_ready, m_valid, "input stalled with no verdict waiting")

endmodule

bind voice_reply_frame_checker_core vrfc_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
) u_vrfc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_verdict      (m_verdict),
    .m_frame_length (m_frame_length)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the voice reply frame checker core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vrfc_pkg::*;

    localparam int MAX_FRAME_BYTES = 128;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_PAD       = 8;
    localparam int IDLE_PCT        = 19;
    localparam int HOLD_CYCLES     = 80;
    localparam int PHASE_BYTES     = 300;

    // Register indexes that map to no register
    localparam logic [7:0] CFG_UNUSED_LOW  = 8'd2;
    localparam logic [7:0] CFG_UNUSED_HIGH = 8'hFF;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] flen;
    } verdict_rec_t;

    typedef struct packed {
        logic [7:0]  rx;
        logic        last;
        logic        typed;
        verdict_t    verdict;
        logic [15:0] flen;
    } dir_row_t;

    // Directed bytes; typed rows carry their verdict, the rest use the predictor
    localparam dir_row_t DIRECTED_TAB [25] = '{
        // lone byte closing a burst: no frame
        '{8'h00, 1'b1, 1'b1, VERDICT_NO_FRAME, 16'd0},
        // repeated start byte, then shortest legal frame
        '{8'hFE, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'hFE, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h99, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h00, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h05, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h01, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h02, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h9F, 1'b1, 1'b0, VERDICT_OK, 16'd0},
        // length below minimum, then a byte ignored after the verdict
        '{8'hFE, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h99, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h00, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h04, 1'b0, 1'b1, VERDICT_LEN_BAD, 16'd4},
        '{8'hFF, 1'b1, 1'b0, VERDICT_OK, 16'd0},
        // largest length field, verdict on the burst end byte
        '{8'hFE, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h99, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'hFF, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'hFF, 1'b1, 1'b1, VERDICT_LEN_BAD, 16'hFFFF},
        // checksum mismatch on a short frame
        '{8'hFE, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h99, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h00, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h05, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h00, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h00, 1'b0, 1'b0, VERDICT_OK, 16'd0},
        '{8'h00, 1'b1, 1'b0, VERDICT_OK, 16'd0}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        s_burst_end;
    logic        m_valid;
    logic        m_ready;
    verdict_t    m_verdict;
    logic [15:0] m_frame_length;

    // Predictor state and register copies
    phase_t      ph;
    logic [7:0]  run_xor;
    logic [15:0] len_val;
    logic [15:0] left_cnt;
    logic        done;
    logic [7:0]  start_reg;
    logic [7:0]  addr_reg;

    verdict_rec_t verdict_q[$];
    verdict_rec_t oldest;
    logic [7:0]   burst_q[$];
    int           err_count;
    int           bytes_sent;
    int           cycle_count;
    int           hold_left;
    bit           hold_req;
    bit           gaps_on;

    voice_reply_frame_checker_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_burst_end    (s_burst_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_frame_length (m_frame_length)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Return the parser to hunting; registers are kept
    task automatic clear_frame();
        ph       = PH_HUNT;
        run_xor  = 8'h00;
        len_val  = 16'd0;
        left_cnt = 16'd0;
        done     = 1'b0;
    endtask

    // Advance the parser by one byte and produce its verdict, if any
    task automatic frame_step(input logic [7:0] rx, input logic last,
                              output bit produced, output verdict_rec_t res);
        produced = 1'b0;
        res      = '0;
        if (!done) begin
            case (ph)
                PH_HUNT: begin
                    if (rx == start_reg) ph = PH_ADDR;
                end
                PH_ADDR: begin
                    // address compare first so equal start and address values work
                    if (rx == addr_reg) begin
                        run_xor = rx;
                        ph      = PH_LEN_HI;
                    end else if (rx != start_reg) begin
                        ph = PH_HUNT;
                    end
                end
                PH_LEN_HI: begin
                    run_xor ^= rx;
                    len_val  = {rx, 8'h00};
                    ph       = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    run_xor ^= rx;
                    len_val  = {len_val[15:8], rx};
                    if (len_val < MIN_FRAME_LENGTH ||
                        (int'(len_val) + 2) > MAX_FRAME_BYTES) begin
                        res      = '{VERDICT_LEN_BAD, len_val};
                        produced = 1'b1;
                    end else begin
                        left_cnt = len_val - 16'd3;
                        ph       = PH_BODY;
                    end
                end
                PH_BODY: begin
                    run_xor ^= rx;
                    left_cnt = left_cnt - 16'd1;
                    if (left_cnt == 16'd0) ph = PH_CHECK;
                end
                PH_CHECK: begin
                    res      = '{(rx == run_xor) ? VERDICT_OK : VERDICT_CS_BAD, len_val};
                    produced = 1'b1;
                end
                default: ;
            endcase
        end
        if (produced) begin
            done = 1'b1;
            ph   = PH_DONE;
        end
        if (last) begin
            if (!produced && !done) begin
                res      = '{VERDICT_NO_FRAME, 16'd0};
                produced = 1'b1;
            end
            clear_frame();
        end
    endtask

    // Offer one byte; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] rx, input logic last,
                             input logic typed, input verdict_rec_t typed_res);
        bit           produced;
        verdict_rec_t res;
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_rx_byte   = rx;
        s_burst_end = last;
        do @(posedge aclk); while (!s_ready);
        frame_step(rx, last, produced, res);
        if (typed) verdict_q.push_back(typed_res);
        else if (produced) verdict_q.push_back(res);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Write one register; called and returns at a falling edge
    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_START_BYTE) start_reg = data;
        else if (idx == CFG_ADDRESS_BYTE) addr_reg = data;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every verdict is out, then let the pipeline settle
    task automatic drain_idle();
        s_valid = 1'b0;
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAD) @(negedge aclk);
    endtask

    // Build one burst: mostly well-formed frames, the rest noise or broken
    task automatic send_burst();
        logic [7:0]  cs;
        logic [7:0]  b;
        logic [15:0] flen;
        int          sel;
        int          cut;
        burst_q.delete();
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
            repeat ($urandom_range(0, 3)) burst_q.push_back(8'($urandom));
            if ($urandom_range(0, 4) == 0) burst_q.push_back(start_reg);
            burst_q.push_back(start_reg);
            cs = ($urandom_range(0, 9) == 0) ? 8'($urandom) : addr_reg;
            burst_q.push_back(cs);
            sel = $urandom_range(0, 99);
            if (sel < 70)      flen = 16'($urandom_range(5, 20));
            else if (sel < 82) flen = 16'($urandom_range(21, 126));
            else if (sel < 88) flen = 16'($urandom_range(126, 127));
            else if (sel < 94) flen = 16'($urandom_range(0, 4));
            else               flen = 16'($urandom_range(127, 65535));
            burst_q.push_back(flen[15:8]);
            burst_q.push_back(flen[7:0]);
            cs ^= flen[15:8] ^ flen[7:0];
            if (flen >= MIN_FRAME_LENGTH && (int'(flen) + 2) <= MAX_FRAME_BYTES) begin
                repeat (int'(flen) - 3) begin
                    b   = 8'($urandom);
                    cs ^= b;
                    burst_q.push_back(b);
                end
                burst_q.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : cs);
            end
            repeat ($urandom_range(0, 2)) burst_q.push_back(8'($urandom));
            // cut the burst short now and then
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, burst_q.size());
                while (burst_q.size() > cut) void'(burst_q.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 2))
                    0:       burst_q.push_back(start_reg);
                    1:       burst_q.push_back(addr_reg);
                    default: burst_q.push_back(8'($urandom));
                endcase
            end
        end
        foreach (burst_q[i]) send_byte(burst_q[i], i == burst_q.size() - 1, 1'b0, '0);
    endtask

    // Stimulus
    initial begin
        int phase_goal;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = 8'd0;
        cfg_data    = 8'd0;
        s_valid     = 1'b0;
        s_rx_byte   = 8'd0;
        s_burst_end = 1'b0;
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        err_count   = 0;
        bytes_sent  = 0;
        start_reg   = START_BYTE_RESET;
        addr_reg    = ADDRESS_BYTE_RESET;
        clear_frame();
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (DIRECTED_TAB[i])
            send_byte(DIRECTED_TAB[i].rx, DIRECTED_TAB[i].last, DIRECTED_TAB[i].typed,
                      '{DIRECTED_TAB[i].verdict, DIRECTED_TAB[i].flen});

        for (int set_i = 0; set_i < 6; set_i++) begin
            drain_idle();
            case (set_i)
                1: begin
                    // extremes, with no idling on either side
                    cfg_write(CFG_START_BYTE, 8'h00);
                    cfg_write(CFG_ADDRESS_BYTE, 8'hFF);
                    gaps_on = 1'b0;
                end
                2: begin
                    gaps_on = 1'b1;
                    cfg_write(CFG_START_BYTE, 8'hFF);
                    cfg_write(CFG_ADDRESS_BYTE, 8'h00);
                end
                3: begin
                    // start and address bytes equal
                    cfg_write(CFG_START_BYTE, 8'hA5);
                    cfg_write(CFG_ADDRESS_BYTE, 8'hA5);
                end
                4: begin
                    cfg_write(CFG_START_BYTE, 8'($urandom));
                    cfg_write(CFG_ADDRESS_BYTE, 8'($urandom));
                    cfg_write(CFG_UNUSED_LOW, 8'($urandom));
                    cfg_write(CFG_UNUSED_HIGH, 8'($urandom));
                end
                5: begin
                    cfg_write(CFG_START_BYTE, START_BYTE_RESET);
                    cfg_write(CFG_ADDRESS_BYTE, ADDRESS_BYTE_RESET);
                end
                default: ;
            endcase
            phase_goal = bytes_sent + PHASE_BYTES;
            // stall the receiver while one-byte bursts pile up verdicts
            if (set_i == 2) begin
                hold_req = 1'b1;
                repeat (40) send_byte(8'($urandom), 1'b1, 1'b0, '0);
            end
            while (bytes_sent < phase_goal) send_burst();
        end

        drain_idle();
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Receiver: random stalls, plus one long hold on request
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready   = 1'b0;
            end else begin
                m_ready = !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Check each verdict transaction against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict %0d length %0d", $time,
                         m_verdict, m_frame_length);
                err_count++;
            end else begin
                oldest = verdict_q.pop_front();
                if (m_verdict !== oldest.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d", $time,
                             oldest.verdict, m_verdict);
                    err_count++;
                end
                if (m_frame_length !== oldest.flen) begin
                    $display("%0t: frame_length expected %0d actual %0d", $time,
                             oldest.flen, m_frame_length);
                    err_count++;
                end
            end
        end
    end

    // Timeout
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule
